// ----- hw/rtl/aca_pkg.sv -----
// shared types and constants of the address cache with aging
`default_nettype none

package aca_pkg;

  // field widths
  localparam int unsigned IpW     = 32;
  localparam int unsigned MacW    = 48;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LifeW   = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned UsedW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 48;

  // command codes
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_LIFETIME = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OWN_IP   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OWN_MAC  = 2'd2;

  // configuration reset values
  localparam logic [LifeW-1:0] LIFETIME_RST = 16'd60;

  // input beat
  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [IpW-1:0]  ip_addr;
    logic [MacW-1:0] mac_addr;
  } req_t;

  // output beat
  typedef struct packed {
    logic             found;
    logic [MacW-1:0]  found_mac;
    logic             evicted;
    logic [UsedW-1:0] entries_used;
  } rsp_t;

  // one cache entry
  typedef struct packed {
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic [TimeW-1:0] expiry;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;  // take the entry of the next cell
    logic load;   // take the new entry
  } cell_ctrl_t;

endpackage : aca_pkg

`default_nettype wire

// ----- hw/rtl/aca_cell.sv -----
// one cache cell: entry storage, ip compare and first-hit chain
`default_nettype none

module aca_cell
  import aca_pkg::*;
(
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire entry_t           next_i,
  input  wire entry_t           new_i,
  input  wire logic             occupied_i,
  input  wire logic [IpW-1:0]   probe_ip_i,
  input  wire logic             seen_i,
  output entry_t                entry_o,
  output logic                  hit_o,
  output logic                  seen_o
);

  entry_t entry_q;
  entry_t entry_d;
  logic   match;

  // load wins over shift
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // first occupied cell holding the probed address
  assign match   = occupied_i && (entry_q.ip == probe_ip_i);
  assign hit_o   = match && !seen_i;
  assign seen_o  = seen_i || match;
  assign entry_o = entry_q;

endmodule : aca_cell

`default_nettype wire

// ----- hw/rtl/address_cache_with_aging.sv -----
// top level of the address cache with aging: sequencer, cell row, result register
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (command, ip, mac)
//   out     | output    | out_valid_o/out_stall_i| out_data_o (found, mac, ...)
//   cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// a beat is accepted, then executed; before execution every
// expired entry is removed from the head of the list, one shift of the cell row each
// an own-ip lookup and a tick never purge
// reset empties the cache and zeroes the seconds counter; no clearing pass
// a result waiting under out_stall_i holds the execute cycle of the next beat;
// purge shifts still proceed meanwhile
`default_nettype none

module address_cache_with_aging
  import aca_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire req_t               in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rsp_t                    out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = $clog2(CACHE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(CACHE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  // configuration registers
  logic [LifeW-1:0] lifetime_q;
  logic [IpW-1:0]   own_ip_q;
  logic [MacW-1:0]  own_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= LIFETIME_RST;
      own_ip_q   <= '0;
      own_mac_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LIFETIME: lifetime_q <= cfg_data_i[LifeW-1:0];
        REG_OWN_IP:   own_ip_q   <= cfg_data_i[IpW-1:0];
        REG_OWN_MAC:  own_mac_q  <= cfg_data_i[MacW-1:0];
        default:      ;
      endcase
    end
  end

  // sequencer and item state
  logic             state_q, state_d;
  req_t             req_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [TimeW-1:0] now_q, now_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_data_q, out_data_d;

  entry_t           entry_w [CACHE_DEPTH];
  logic             hit_w   [CACHE_DEPTH];
  logic             seen_w  [CACHE_DEPTH+1];
  cell_ctrl_t       ctrl_w  [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] load_vec;

  logic             in_accept;
  logic             own_hit;
  logic             uses_cache;
  logic [TimeW-1:0] head_diff;
  logic             head_alive;
  logic             needs_purge;
  logic             out_free;
  logic             exec;
  logic             purge_shift;
  logic             is_insert;
  logic             any_hit;
  logic             full;
  logic             ins_shift;
  logic [CntW-1:0]  count_after;
  logic [MacW-1:0]  hit_mac;
  entry_t           new_entry;
  logic [CntW+UsedW-1:0] used_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // head entry age check, wrap-safe signed difference
  assign head_diff  = entry_w[0].expiry - now_q;
  assign head_alive = (head_diff != '0) && !head_diff[TimeW-1];

  assign own_hit     = (req_q.command == CMD_LOOKUP) && (req_q.ip_addr == own_ip_q);
  assign is_insert   = (req_q.command == CMD_INSERT);
  assign uses_cache  = ((req_q.command == CMD_LOOKUP) && !own_hit) || is_insert;
  assign needs_purge = uses_cache && (count_q != '0) && !head_alive;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign purge_shift = (state_q == ST_WORK) && needs_purge;
  assign exec        = (state_q == ST_WORK) && !needs_purge && out_free;

  // insert bookkeeping: drop a matching entry or the oldest one when full
  assign any_hit     = seen_w[CACHE_DEPTH];
  assign full        = (count_q == DepthC);
  assign ins_shift   = any_hit || full;
  assign count_after = count_q - CntW'(ins_shift);

  assign new_entry.ip     = req_q.ip_addr;
  assign new_entry.mac    = req_q.mac_addr;
  assign new_entry.expiry = now_q + TimeW'(lifetime_q);

  // cell row
  assign seen_w[0] = 1'b0;

  for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
    entry_t next_entry;
    logic   occupied;

    if (k == CACHE_DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = entry_w[k+1];
    end

    // a matching entry closes its own gap; on insert only a full cache without a match drops the head
    assign occupied        = (CntW'(k) < count_q);
    assign ctrl_w[k].shift = purge_shift ||
                             (exec && is_insert && (seen_w[k+1] || (full && !any_hit)));
    assign ctrl_w[k].load  = exec && is_insert && (count_after == CntW'(k));
    assign load_vec[k]     = ctrl_w[k].load;

    aca_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_w[k]),
      .next_i     (next_entry),
      .new_i      (new_entry),
      .occupied_i (occupied),
      .probe_ip_i (req_q.ip_addr),
      .seen_i     (seen_w[k]),
      .entry_o    (entry_w[k]),
      .hit_o      (hit_w[k]),
      .seen_o     (seen_w[k+1])
    );
  end

  // first-hit mac, hit is one-hot or zero
  always_comb begin
    hit_mac = '0;
    for (int k = 0; k < CACHE_DEPTH; k++) begin
      hit_mac = hit_mac | ({MacW{hit_w[k]}} & entry_w[k].mac);
    end
  end

  // next state, counters and result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    now_d       = now_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    used_ext    = '0;

    if (in_accept) begin
      state_d = ST_WORK;
    end

    if (purge_shift) begin
      count_d = count_q - CntW'(1);
    end

    if (exec) begin
      state_d                = ST_IDLE;
      out_valid_d            = 1'b1;
      out_data_d.found       = 1'b0;
      out_data_d.found_mac   = '0;
      out_data_d.evicted     = 1'b0;
      case (req_q.command)
        CMD_LOOKUP: begin
          if (own_hit) begin
            out_data_d.found     = 1'b1;
            out_data_d.found_mac = own_mac_q;
          end else begin
            out_data_d.found     = any_hit;
            out_data_d.found_mac = hit_mac;
          end
        end
        CMD_INSERT: begin
          out_data_d.evicted = full && !any_hit;
          count_d            = count_after + CntW'(1);
        end
        CMD_TICK: begin
          now_d = now_q + TimeW'(1);
        end
        default: ;
      endcase
      used_ext                = {{UsedW{1'b0}}, count_d};
      out_data_d.entries_used = used_ext[UsedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above cache depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !exec)
    else $error("result overwritten while stalled");

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(load_vec))
    else $error("more than one cell loaded");

  a_purge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    purge_shift |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("purge shift did not drop one entry");

endmodule : address_cache_with_aging

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for the address cache with aging: directed and random beats scored against a cache model
module tb_top;
  import aca_pkg::*;

  localparam int unsigned CACHE_DEPTH = 16;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BEATS = 72;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 300;
  localparam logic [MacW-1:0] MAC_ONES = '1;
  localparam logic [IpW-1:0]  IP_ONES  = '1;

  // dut connections, all inputs known from time zero
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  req_t               in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rsp_t               out_data;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  // cache model state and its copy of the registers
  entry_t             cache_q[$];
  logic [TimeW-1:0]   now_s       = '0;
  logic [LifeW-1:0]   life_cfg    = LIFETIME_RST;
  logic [IpW-1:0]     own_ip_cfg  = '0;
  logic [MacW-1:0]    own_mac_cfg = '0;

  // stimulus and scoreboard storage
  req_t               req_pending_q[$];
  rsp_t               rsp_due_q[$];
  logic [IpW-1:0]     ip_pool [POOL_SIZE];
  int                 pool_span = POOL_SIZE;
  int                 phase_life [NUM_PHASES];

  // sender and receiver pacing
  logic               req_taken  = 1'b0;
  int                 burst_left = 8;
  int                 gap_left   = 0;
  int                 hold_left  = 0;
  logic               hold_done  = 1'b0;
  int unsigned        stall_tick = 0;
  int                 stall_mode = 0;

  // run statistics
  int                 errors       = 0;
  int                 results_seen = 0;
  int                 n_lookup     = 0;
  int                 n_hit        = 0;
  int                 n_insert     = 0;
  int                 n_evict      = 0;
  int                 n_tick       = 0;
  int                 n_other      = 0;
  int                 n_writes     = 0;
  int                 peak_used    = 0;

  address_cache_with_aging #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // drop the leading run of entries that are no longer alive
  function automatic void purge_expired();
    logic [TimeW-1:0] left;
    while (cache_q.size() > 0) begin
      left = cache_q[0].expiry - now_s;
      if (left != '0 && !left[TimeW-1]) break;
      cache_q.delete(0);
    end
  endfunction

  // apply one beat to the cache model and return the response it produces
  function automatic rsp_t cache_apply(req_t r);
    rsp_t   res;
    int     idx;
    entry_t e;
    res = '0;
    idx = -1;
    case (r.command)
      CMD_LOOKUP: begin
        if (r.ip_addr == own_ip_cfg) begin
          res.found     = 1'b1;
          res.found_mac = own_mac_cfg;
        end else begin
          purge_expired();
          foreach (cache_q[i]) if (idx < 0 && cache_q[i].ip == r.ip_addr) idx = i;
          if (idx >= 0) begin
            res.found     = 1'b1;
            res.found_mac = cache_q[idx].mac;
          end
        end
      end
      CMD_INSERT: begin
        purge_expired();
        foreach (cache_q[i]) if (idx < 0 && cache_q[i].ip == r.ip_addr) idx = i;
        if (idx >= 0) cache_q.delete(idx);
        if (cache_q.size() >= CACHE_DEPTH) begin
          cache_q.delete(0);
          res.evicted = 1'b1;
        end
        e.ip     = r.ip_addr;
        e.mac    = r.mac_addr;
        e.expiry = now_s + TimeW'(life_cfg);
        cache_q.push_back(e);
      end
      CMD_TICK: begin
        now_s = now_s + 1'b1;
      end
      default: ;
    endcase
    res.entries_used = UsedW'(cache_q.size());
    return res;
  endfunction

  function automatic req_t beat(logic [CmdW-1:0] cmd, logic [IpW-1:0] ip,
                                logic [MacW-1:0] mac);
    req_t r;
    r.command  = cmd;
    r.ip_addr  = ip;
    r.mac_addr = mac;
    return r;
  endfunction

  // random beat, addresses mostly from a small pool so entries get hit and refreshed
  function automatic req_t rand_req();
    req_t        r;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 38) r.command = CMD_INSERT;
    else if (k < 75) r.command = CMD_LOOKUP;
    else if (k < 95) r.command = CMD_TICK;
    else r.command = CMD_UNUSED;
    k = $urandom_range(0, 99);
    if (k < 8) r.ip_addr = own_ip_cfg;
    else if (k < 88) r.ip_addr = ip_pool[$urandom_range(0, pool_span - 1)];
    else r.ip_addr = $urandom;
    r.mac_addr = {16'($urandom), 32'($urandom)};
    return r;
  endfunction

  // register write, only issued while the cache is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_LIFETIME: life_cfg    = val[LifeW-1:0];
      REG_OWN_IP:   own_ip_cfg  = val[IpW-1:0];
      REG_OWN_MAC:  own_mac_cfg = val[MacW-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // wait until every queued beat has been sent and answered
  task automatic drain();
    while (req_pending_q.size() != 0 || in_valid || rsp_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of beats separated by idle gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= req_pending_q.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                        $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off while beats keep coming
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150 && req_pending_q.size() > 20) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 7) == 0);
        2:       out_stall <= $urandom_range(0, 1);
        default: out_stall <= (stall_tick[2:0] < 3'd3);
      endcase
    end
  end

  // scoreboard: check response beats, then predict newly accepted request beats
  always @(posedge clk) begin : score
    rsp_t want;
    req_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if ($isunknown({in_stall, out_valid})) begin
        $error("handshake output unknown: in_stall %b out_valid %b", in_stall, out_valid);
        errors++;
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (rsp_due_q.size() == 0) begin
          $error("response beat with no request outstanding");
          errors++;
        end else begin
          want = rsp_due_q.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0h actual %0h", want.found, out_data.found);
            errors++;
          end
          if (out_data.found_mac !== want.found_mac) begin
            $error("found_mac: expected %0h actual %0h", want.found_mac, out_data.found_mac);
            errors++;
          end
          if (out_data.evicted !== want.evicted) begin
            $error("evicted: expected %0h actual %0h", want.evicted, out_data.evicted);
            errors++;
          end
          if (out_data.entries_used !== want.entries_used) begin
            $error("entries_used: expected %0d actual %0d", want.entries_used,
                   out_data.entries_used);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = cache_apply(in_data);
        rsp_due_q.push_back(want);
        case (in_data.command)
          CMD_LOOKUP: begin
            n_lookup++;
            if (want.found) n_hit++;
          end
          CMD_INSERT: begin
            n_insert++;
            if (want.evicted) n_evict++;
          end
          CMD_TICK: n_tick++;
          default:  n_other++;
        endcase
        if (int'(want.entries_used) > peak_used) peak_used = want.entries_used;
      end
    end
  end

  // overall time limit
  initial begin
    #500_000;
    $display("TB_ERROR");
    $finish;
  end

  // test sequence
  initial begin
    int          life;
    logic [IpW-1:0]  oip;
    logic [MacW-1:0] omac;
    phase_life = '{1, 65535, 4, 30, 2, 0, 8, -1};
    ip_pool[0] = '0;
    ip_pool[1] = IP_ONES;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: own address is zero, lifetime 60
    req_pending_q.push_back(beat(CMD_LOOKUP, '0, '0));
    req_pending_q.push_back(beat(CMD_LOOKUP, IP_ONES, '0));
    req_pending_q.push_back(beat(CMD_INSERT, '0, MAC_ONES));
    req_pending_q.push_back(beat(CMD_LOOKUP, '0, MAC_ONES));
    req_pending_q.push_back(beat(CMD_UNUSED, IP_ONES, MAC_ONES));
    req_pending_q.push_back(beat(CMD_TICK, IP_ONES, MAC_ONES));
    drain();

    // short lifetime: refresh, own address stored, expired entries purged
    write_reg(REG_LIFETIME, CfgW'(2));
    write_reg(REG_OWN_IP, CfgW'(32'hC0A8_0001));
    write_reg(REG_OWN_MAC, CfgW'(48'h0200_5E00_0001));
    req_pending_q.push_back(beat(CMD_INSERT, IP_ONES, MAC_ONES));
    req_pending_q.push_back(beat(CMD_INSERT, 32'h0A00_0001, 48'h1234_5678_9ABC));
    req_pending_q.push_back(beat(CMD_INSERT, 32'hC0A8_0001, 48'hAAAA_5555_AAAA));
    req_pending_q.push_back(beat(CMD_LOOKUP, IP_ONES, '0));
    req_pending_q.push_back(beat(CMD_LOOKUP, 32'hC0A8_0001, '0));
    req_pending_q.push_back(beat(CMD_INSERT, IP_ONES, '0));
    req_pending_q.push_back(beat(CMD_LOOKUP, IP_ONES, MAC_ONES));
    req_pending_q.push_back(beat(CMD_TICK, '0, '0));
    req_pending_q.push_back(beat(CMD_TICK, '0, '0));
    req_pending_q.push_back(beat(CMD_LOOKUP, 32'h0A00_0001, '0));
    req_pending_q.push_back(beat(CMD_LOOKUP, 32'hC0A8_0001, '0));
    req_pending_q.push_back(beat(CMD_INSERT, '0, 48'h0000_0000_0001));
    req_pending_q.push_back(beat(CMD_LOOKUP, 32'h0A00_0001, '0));
    req_pending_q.push_back(beat(CMD_LOOKUP, '0, '0));

    // random phases, each with its own lifetime and local address
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      life = (phase_life[p] < 0) ? $urandom_range(1, 50) : phase_life[p];
      case (p % 4)
        0:       oip = IP_ONES;
        1:       oip = '0;
        2:       oip = ip_pool[$urandom_range(2, 11)];
        default: oip = $urandom;
      endcase
      case (p % 3)
        0:       omac = MAC_ONES;
        1:       omac = '0;
        default: omac = {16'($urandom), 32'($urandom)};
      endcase
      write_reg(REG_LIFETIME, CfgW'(life));
      write_reg(REG_OWN_IP, CfgW'(oip));
      write_reg(REG_OWN_MAC, omac);
      pool_span = (p % 2 == 0) ? 12 : POOL_SIZE;
      repeat (PHASE_BEATS) req_pending_q.push_back(rand_req());
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d lookups (%0d hits), %0d inserts (%0d evictions), %0d ticks, %0d other",
             n_lookup, n_hit, n_insert, n_evict, n_tick, n_other);
    $display("%0d register writes, peak occupancy %0d, one receiver hold of %0d cycles",
             n_writes, peak_used, HOLD_CYCLES);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/aca_pkg.sv
hw/rtl/aca_cell.sv
hw/rtl/address_cache_with_aging.sv
tb/tb_top.sv
